[rtl/mshm_pkg.sv]
// ----------------------------------------------------------------------------
// mshm_pkg
// Types and constants shared by the sensor health monitor modules.
// ----------------------------------------------------------------------------
package mshm_pkg;

	localparam int MASK_W    = 6;
	localparam int MAX_LANES = 8;
	localparam int CH_W      = 3;
	localparam int ANGLE_W   = 16;
	localparam int RAW_W     = 12;
	localparam int BYTE_W    = 8;
	localparam int CNT_W     = 3;
	localparam int ROUND_W   = 32;

	localparam logic [ANGLE_W-1:0] ANGLE_NONE = 16'hFFFF;
	localparam logic [BYTE_W-1:0]  AGC_NONE   = 8'hFF;
	localparam logic [BYTE_W-1:0]  STREAK_MAX = 8'hFF;
	localparam logic [CNT_W-1:0]   FAIL_MAX   = 3'd7;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_CHAN  = 2'd1,
		CMD_END   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_CHANNEL_ENABLE = 2'd0,
		REG_STATUS_DECIM   = 2'd1,
		REG_RECOVER_THR    = 2'd2,
		REG_MUX_RESET_THR  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [CH_W-1:0]   channel;
		logic              angle_ok;
		logic [RAW_W-1:0]  angle;
		logic              status_ok;
		logic              magnet_present;
		logic [BYTE_W-1:0] agc_reading;
		logic              recover_ok;
	} item_t;

	typedef struct packed {
		logic               read_status_now;
		logic [CH_W-1:0]    result_channel;
		logic [ANGLE_W-1:0] angle_value;
		logic [BYTE_W-1:0]  agc_value;
		logic               channel_good;
		logic               recover_pending;
		logic [MASK_W-1:0]  good_mask;
		logic [MASK_W-1:0]  comm_fault_mask;
		logic               degraded;
		logic               mux_alarm;
		logic               mux_reset_request;
		logic [ROUND_W-1:0] round_count;
	} result_t;

	typedef struct packed {
		logic [MASK_W-1:0] channel_enable;
		logic [BYTE_W-1:0] status_decimation;
		logic [BYTE_W-1:0] recover_threshold;
		logic [BYTE_W-1:0] mux_reset_threshold;
	} cfg_t;

	typedef struct packed {
		logic              load;
		logic [BYTE_W-1:0] value;
	} cnt_load_t;

endpackage

[rtl/mshm_if.sv]
// ----------------------------------------------------------------------------
// mshm_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mshm_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [2:0]  channel;
	logic        angle_ok;
	logic [11:0] angle;
	logic        status_ok;
	logic        magnet_present;
	logic [7:0]  agc_reading;
	logic        recover_ok;

	modport source (output valid, cmd, channel, angle_ok, angle, status_ok, magnet_present,
		agc_reading, recover_ok, input ready);
	modport sink (input valid, cmd, channel, angle_ok, angle, status_ok, magnet_present,
		agc_reading, recover_ok, output ready);
endinterface

interface mshm_result_if;
	logic        valid;
	logic        ready;
	logic        read_status_now;
	logic [2:0]  result_channel;
	logic [15:0] angle_value;
	logic [7:0]  agc_value;
	logic        channel_good;
	logic        recover_pending;
	logic [5:0]  good_mask;
	logic [5:0]  comm_fault_mask;
	logic        degraded;
	logic        mux_alarm;
	logic        mux_reset_request;
	logic [31:0] round_count;

	modport source (output valid, read_status_now, result_channel, angle_value, agc_value,
		channel_good, recover_pending, good_mask, comm_fault_mask, degraded, mux_alarm,
		mux_reset_request, round_count, input ready);
	modport sink (input valid, read_status_now, result_channel, angle_value, agc_value,
		channel_good, recover_pending, good_mask, comm_fault_mask, degraded, mux_alarm,
		mux_reset_request, round_count, output ready);
endinterface

[rtl/mshm_cfg.sv]
// ----------------------------------------------------------------------------
// mshm_cfg
// Configuration registers and the decimation counter load request.
// ----------------------------------------------------------------------------
module mshm_cfg
	import mshm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [BYTE_W-1:0] wr_data,
	output cfg_t              cfg,
	output cnt_load_t         cnt_load
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_enable      <= '0;
			cfg_q.status_decimation   <= 8'd1;
			cfg_q.recover_threshold   <= 8'd3;
			cfg_q.mux_reset_threshold <= 8'd3;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_CHANNEL_ENABLE: cfg_q.channel_enable      <= wr_data[MASK_W-1:0];
				REG_STATUS_DECIM:   cfg_q.status_decimation   <= wr_data;
				REG_RECOVER_THR:    cfg_q.recover_threshold   <= wr_data;
				REG_MUX_RESET_THR:  cfg_q.mux_reset_threshold <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg            = cfg_q;
	assign cnt_load.load  = wr_en && (reg_idx_t'(wr_index) == REG_STATUS_DECIM);
	assign cnt_load.value = wr_data - 8'd1;

endmodule

[rtl/mshm_engine.sv]
// ----------------------------------------------------------------------------
// mshm_engine
// Round and per-channel health state with the single-pass update logic.
// ----------------------------------------------------------------------------
module mshm_engine
	import mshm_pkg::*;
#(
	parameter int CHANNELS = 6
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  item_t     item,
	input  cfg_t      cfg,
	input  cnt_load_t cnt_load,
	output result_t   res
);

	localparam logic [MASK_W-1:0] LANE_MASK = MASK_W'((1 << CHANNELS) - 1);

	logic [ANGLE_W-1:0] angle_q [CHANNELS];
	logic [BYTE_W-1:0]  agc_q [CHANNELS];
	logic [BYTE_W-1:0]  streak_q [CHANNELS];
	logic [ANGLE_W-1:0] angle_n [CHANNELS];
	logic [BYTE_W-1:0]  agc_n [CHANNELS];
	logic [BYTE_W-1:0]  streak_n [CHANNELS];

	logic [BYTE_W-1:0]  cnt_q, cnt_n;
	logic               sr_q, sr_n;
	logic [MASK_W-1:0]  magnet_q, magnet_n;
	logic [MASK_W-1:0]  good_q, good_n;
	logic [MASK_W-1:0]  faults_q, faults_n;
	logic [CNT_W-1:0]   fc_q, fc_n;
	logic               deg_q, deg_n;
	logic               rec_q, rec_n;
	logic [BYTE_W-1:0]  ffr_q, ffr_n;
	logic [ROUND_W-1:0] rounds_q, rounds_n;

	logic [MASK_W-1:0]    en, chbit;
	logic [MAX_LANES-1:0] en_wide;
	logic                 in_range, hit;
	logic [ANGLE_W-1:0]   cur_angle, na;
	logic [BYTE_W-1:0]    cur_agc, ng, cur_streak, ns, cnt_inc, ffr_inc;
	logic [CNT_W-1:0]     pop, fc_sat;

	always_comb begin
		en       = cfg.channel_enable & LANE_MASK;
		en_wide  = MAX_LANES'(en);
		chbit    = MASK_W'(MAX_LANES'(1) << item.channel);
		in_range = {1'b0, item.channel} < (CH_W+1)'(CHANNELS);
		hit      = in_range && en_wide[item.channel];

		cur_angle  = ANGLE_NONE;
		cur_agc    = AGC_NONE;
		cur_streak = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (item.channel == CH_W'(i)) begin
				cur_angle  = angle_q[i];
				cur_agc    = agc_q[i];
				cur_streak = streak_q[i];
			end
		end

		pop = '0;
		for (int j = 0; j < MASK_W; j++) begin
			pop = pop + CNT_W'(en[j]);
		end

		cnt_inc = cnt_q + 8'd1;
		ffr_inc = ffr_q + 8'd1;
		fc_sat  = (fc_q == FAIL_MAX) ? fc_q : fc_q + 3'd1;

		angle_n  = angle_q;
		agc_n    = agc_q;
		streak_n = streak_q;
		cnt_n    = cnt_q;
		sr_n     = sr_q;
		magnet_n = magnet_q;
		good_n   = good_q;
		faults_n = faults_q;
		fc_n     = fc_q;
		deg_n    = deg_q;
		rec_n    = rec_q;
		ffr_n    = ffr_q;
		rounds_n = rounds_q;
		na       = cur_angle;
		ng       = cur_agc;
		ns       = cur_streak;
		res      = '0;

		case (cmd_t'(item.cmd))
			CMD_START: begin
				if (cnt_inc >= cfg.status_decimation) begin
					cnt_n = '0;
					sr_n  = 1'b1;
				end else begin
					cnt_n = cnt_inc;
					sr_n  = 1'b0;
				end
				good_n   = '0;
				faults_n = '0;
				fc_n     = '0;
				deg_n    = 1'b0;
				rec_n    = 1'b0;
				for (int i = 0; i < CHANNELS; i++) begin
					if (!en_wide[i]) begin
						angle_n[i]  = ANGLE_NONE;
						agc_n[i]    = AGC_NONE;
						streak_n[i] = '0;
					end
				end
				res.read_status_now = sr_n;
				res.round_count     = rounds_q;
			end
			CMD_CHAN: begin
				if (hit) begin
					if (!item.angle_ok) begin
						faults_n = faults_q | chbit;
						deg_n    = 1'b1;
						ng       = '0;
						ns       = (cur_streak == STREAK_MAX) ? cur_streak : cur_streak + 8'd1;
						fc_n     = fc_sat;
						if (ns >= cfg.recover_threshold) begin
							rec_n = 1'b1;
						end
					end else begin
						na = ANGLE_W'(item.angle);
						ns = '0;
						if (sr_q && !item.status_ok) begin
							faults_n = faults_q | chbit;
							deg_n    = 1'b1;
							ng       = '0;
							ns       = 8'd1;
							fc_n     = fc_sat;
						end else begin
							if (sr_q) begin
								ng       = item.agc_reading;
								magnet_n = item.magnet_present ? (magnet_q | chbit)
								                               : (magnet_q & ~chbit);
							end
							if ((magnet_n & chbit) != '0) begin
								good_n = good_q | chbit;
							end else begin
								deg_n = 1'b1;
							end
						end
					end
					for (int i = 0; i < CHANNELS; i++) begin
						if (item.channel == CH_W'(i)) begin
							angle_n[i]  = na;
							agc_n[i]    = ng;
							streak_n[i] = ns;
						end
					end
				end
				res.result_channel  = item.channel;
				res.angle_value     = na;
				res.agc_value       = ng;
				res.channel_good    = in_range && ((good_n & chbit) != '0);
				res.recover_pending = rec_n;
				res.comm_fault_mask = faults_n;
				res.round_count     = rounds_q;
			end
			CMD_END: begin
				if (rec_q) begin
					res.mux_alarm = !item.recover_ok;
					for (int i = 0; i < CHANNELS; i++) begin
						streak_n[i] = '0;
					end
				end
				if ((en != '0) && (fc_q == pop)) begin
					ffr_n = ffr_inc;
					if (ffr_inc >= cfg.mux_reset_threshold) begin
						res.mux_reset_request = 1'b1;
						res.mux_alarm         = 1'b1;
						ffr_n                 = '0;
					end
				end else begin
					ffr_n = '0;
				end
				rounds_n            = rounds_q + 32'd1;
				res.recover_pending = rec_q;
				res.good_mask       = good_q;
				res.comm_fault_mask = faults_q;
				res.degraded        = deg_q || ((good_q & en) != en);
				res.round_count     = rounds_n;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				angle_q[i]  <= ANGLE_NONE;
				agc_q[i]    <= AGC_NONE;
				streak_q[i] <= '0;
			end
			cnt_q    <= '0;
			sr_q     <= 1'b0;
			magnet_q <= '0;
			good_q   <= '0;
			faults_q <= '0;
			fc_q     <= '0;
			deg_q    <= 1'b0;
			rec_q    <= 1'b0;
			ffr_q    <= '0;
			rounds_q <= '0;
		end else begin
			if (cnt_load.load) begin
				cnt_q <= cnt_load.value;
			end else if (fire) begin
				cnt_q <= cnt_n;
			end
			if (fire) begin
				angle_q  <= angle_n;
				agc_q    <= agc_n;
				streak_q <= streak_n;
				sr_q     <= sr_n;
				magnet_q <= magnet_n;
				good_q   <= good_n;
				faults_q <= faults_n;
				fc_q     <= fc_n;
				deg_q    <= deg_n;
				rec_q    <= rec_n;
				ffr_q    <= ffr_n;
				rounds_q <= rounds_n;
			end
		end
	end

endmodule

[rtl/multichannel_sensor_health_monitor.sv]
// ----------------------------------------------------------------------------
// multichannel_sensor_health_monitor
// Tracks scan rounds over multiplexed angle-sensor channels and reports health.
// ----------------------------------------------------------------------------
// An accepted item is held in the input register; its result is then taken
// into the result register when the output side can advance.
// Throughput: one item per cycle unless the result side stalls; the input register
// and result register let a new item enter while a finished result waits to be taken.
// Reset: arst_n clears control state, configuration and all channel stores.
module multichannel_sensor_health_monitor
	import mshm_pkg::*;
#(
	parameter int CHANNELS = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	mshm_item_if.sink           item,
	mshm_result_if.source       result,
	input  logic                wr_en,
	input  logic [1:0]          wr_index,
	input  logic [BYTE_W-1:0]   wr_data
);

	cfg_t      cfg;
	cnt_load_t cnt_load;
	item_t     item_s1;
	logic      valid_s1;
	result_t   res;
	result_t   res_s2;
	logic      valid_s2;
	logic      advance;

	assign advance    = !valid_s2 || result.ready;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1 && (cmd_t'(item_s1.cmd) != CMD_NONE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.cmd            <= item.cmd;
			item_s1.channel        <= item.channel;
			item_s1.angle_ok       <= item.angle_ok;
			item_s1.angle          <= item.angle;
			item_s1.status_ok      <= item.status_ok;
			item_s1.magnet_present <= item.magnet_present;
			item_s1.agc_reading    <= item.agc_reading;
			item_s1.recover_ok     <= item.recover_ok;
		end
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	mshm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg),
		.cnt_load (cnt_load)
	);

	mshm_engine #(
		.CHANNELS (CHANNELS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (valid_s1 && advance),
		.item     (item_s1),
		.cfg      (cfg),
		.cnt_load (cnt_load),
		.res      (res)
	);

	assign result.valid             = valid_s2;
	assign result.read_status_now   = res_s2.read_status_now;
	assign result.result_channel    = res_s2.result_channel;
	assign result.angle_value       = res_s2.angle_value;
	assign result.agc_value         = res_s2.agc_value;
	assign result.channel_good      = res_s2.channel_good;
	assign result.recover_pending   = res_s2.recover_pending;
	assign result.good_mask         = res_s2.good_mask;
	assign result.comm_fault_mask   = res_s2.comm_fault_mask;
	assign result.degraded          = res_s2.degraded;
	assign result.mux_alarm         = res_s2.mux_alarm;
	assign result.mux_reset_request = res_s2.mux_reset_request;
	assign result.round_count       = res_s2.round_count;

endmodule

[rtl/mshm_chk.sv]
// ----------------------------------------------------------------------------
// mshm_chk
// Port-level checks for the sensor health monitor, bound to the top level.
// ----------------------------------------------------------------------------
module mshm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        degraded,
	input logic        mux_alarm,
	input logic        mux_reset_request,
	input logic [31:0] round_count
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(round_count))
		else $error("Stalled result beat changed.");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("Input stalled while the result side was free.");

	a_reset_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mux_reset_request |-> mux_alarm)
		else $error("Mux reset request without mux fault.");

	a_reset_degraded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mux_reset_request |-> degraded)
		else $error("Mux reset request in a round that was not degraded.");

	a_idle_in: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready) || !$past(arst_n))
		else $error("Result beat withdrawn before it was taken.");

endmodule

bind multichannel_sensor_health_monitor mshm_chk u_mshm_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (item.valid),
	.in_ready          (item.ready),
	.out_valid         (result.valid),
	.out_ready         (result.ready),
	.degraded          (result.degraded),
	.mux_alarm         (result.mux_alarm),
	.mux_reset_request (result.mux_reset_request),
	.round_count       (result.round_count)
);

[sim/multichannel_sensor_health_monitor_checker.sv]
// ----------------------------------------------------------------------------
// multichannel_sensor_health_monitor_checker
// Watches the item, result and register write ports of the health monitor,
// keeps its own copy of the monitor state and settings, predicts the result
// beat of every accepted item but CMD_NONE, compares it field by field with what the
// block returns. The number of failures and of results still due go to the top.
// ----------------------------------------------------------------------------
module multichannel_sensor_health_monitor_checker
	import mshm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	mshm_item_if              item_bus,
	mshm_result_if            result_bus,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [BYTE_W-1:0] wr_data,
	output int                errors,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH = 6;

	cfg_t               cfg;
	logic [BYTE_W-1:0]  status_cnt;
	logic               status_rd;
	logic [ANGLE_W-1:0] angle_mem [NCH];
	logic [BYTE_W-1:0]  gain_mem [NCH];
	logic [BYTE_W-1:0]  streak [NCH];
	logic [MASK_W-1:0]  magnet_bits;
	logic [MASK_W-1:0]  good_bits;
	logic [MASK_W-1:0]  fault_bits;
	logic [CNT_W-1:0]   fail_cnt;
	logic               degraded_flag;
	logic               recover_req;
	logic [BYTE_W-1:0]  total_fail_rounds;
	logic [ROUND_W-1:0] round_num;

	result_t pending_reports [$];

	function automatic void clear_monitor();
		cfg.channel_enable = '0;
		cfg.status_decimation = 8'd1;
		cfg.recover_threshold = 8'd3;
		cfg.mux_reset_threshold = 8'd3;
		status_cnt = 8'd0;
		status_rd = 1'b0;
		for (int i = 0; i < NCH; i++) begin
			angle_mem[i] = ANGLE_NONE;
			gain_mem[i] = AGC_NONE;
			streak[i] = '0;
		end
		magnet_bits = '0;
		good_bits = '0;
		fault_bits = '0;
		fail_cnt = '0;
		degraded_flag = 1'b0;
		recover_req = 1'b0;
		total_fail_rounds = '0;
		round_num = '0;
	endfunction

	function automatic void write_setting(logic [1:0] idx, logic [BYTE_W-1:0] value);
		case (reg_idx_t'(idx))
			REG_CHANNEL_ENABLE: cfg.channel_enable = value[MASK_W-1:0];
			REG_STATUS_DECIM: begin
				cfg.status_decimation = value;
				status_cnt = value - 8'd1;
			end
			REG_RECOVER_THR: cfg.recover_threshold = value;
			REG_MUX_RESET_THR: cfg.mux_reset_threshold = value;
			default: ;
		endcase
	endfunction

	function automatic void note_comm_fault(logic [CH_W-1:0] ch);
		fault_bits[ch] = 1'b1;
		degraded_flag = 1'b1;
		gain_mem[ch] = '0;
		if (streak[ch] != STREAK_MAX)
			streak[ch] = streak[ch] + 8'd1;
		if (fail_cnt < FAIL_MAX)
			fail_cnt = fail_cnt + 3'd1;
	endfunction

	function automatic result_t health_report(item_t it);
		result_t           r;
		logic [MASK_W-1:0] en;
		logic [CH_W-1:0]   ch;
		logic              status_fail;
		logic              mux_alarm;
		logic              mux_rst;
		r = '0;
		en = cfg.channel_enable;
		ch = it.channel;
		case (cmd_t'(it.cmd))
			CMD_START: begin
				status_cnt = status_cnt + 8'd1;
				status_rd = 1'b0;
				if (status_cnt >= cfg.status_decimation) begin
					status_cnt = '0;
					status_rd = 1'b1;
				end
				good_bits = '0;
				fault_bits = '0;
				fail_cnt = '0;
				degraded_flag = 1'b0;
				recover_req = 1'b0;
				for (int i = 0; i < NCH; i++) begin
					if (!en[i]) begin
						angle_mem[i] = ANGLE_NONE;
						gain_mem[i] = AGC_NONE;
						streak[i] = '0;
					end
				end
				r.read_status_now = status_rd;
				r.round_count = round_num;
			end
			CMD_CHAN: begin
				r.result_channel = ch;
				if (ch >= NCH) begin
					r.angle_value = ANGLE_NONE;
					r.agc_value = AGC_NONE;
				end else begin
					if (en[ch]) begin
						if (!it.angle_ok) begin
							note_comm_fault(ch);
							if (streak[ch] >= cfg.recover_threshold)
								recover_req = 1'b1;
						end else begin
							status_fail = 1'b0;
							angle_mem[ch] = ANGLE_W'(it.angle);
							streak[ch] = '0;
							if (status_rd) begin
								if (!it.status_ok) begin
									note_comm_fault(ch);
									status_fail = 1'b1;
								end else begin
									gain_mem[ch] = it.agc_reading;
									magnet_bits[ch] = it.magnet_present;
								end
							end
							if (!status_fail) begin
								if (magnet_bits[ch])
									good_bits[ch] = 1'b1;
								else
									degraded_flag = 1'b1;
							end
						end
					end
					r.angle_value = angle_mem[ch];
					r.agc_value = gain_mem[ch];
					r.channel_good = good_bits[ch];
				end
				r.recover_pending = recover_req;
				r.comm_fault_mask = fault_bits;
				r.round_count = round_num;
			end
			default: begin
				mux_alarm = 1'b0;
				mux_rst = 1'b0;
				if (recover_req) begin
					if (!it.recover_ok)
						mux_alarm = 1'b1;
					for (int i = 0; i < NCH; i++)
						streak[i] = '0;
				end
				if (en != '0 && int'(fail_cnt) == $countones(en)) begin
					total_fail_rounds = total_fail_rounds + 8'd1;
					if (total_fail_rounds >= cfg.mux_reset_threshold) begin
						mux_rst = 1'b1;
						mux_alarm = 1'b1;
						total_fail_rounds = '0;
					end
				end else begin
					total_fail_rounds = '0;
				end
				round_num = round_num + 32'd1;
				r.recover_pending = recover_req;
				r.good_mask = good_bits;
				r.comm_fault_mask = fault_bits;
				r.degraded = degraded_flag || ((good_bits & en) != en);
				r.mux_alarm = mux_alarm;
				r.mux_reset_request = mux_rst;
				r.round_count = round_num;
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		item_t   seen;
		result_t got;
		result_t want;
		if (!arst_n) begin
			clear_monitor();
			pending_reports.delete();
			outstanding = 0;
		end else begin
			if (wr_en)
				write_setting(wr_index, wr_data);
			if (result_bus.valid && result_bus.ready) begin
				got.read_status_now = result_bus.read_status_now;
				got.result_channel = result_bus.result_channel;
				got.angle_value = result_bus.angle_value;
				got.agc_value = result_bus.agc_value;
				got.channel_good = result_bus.channel_good;
				got.recover_pending = result_bus.recover_pending;
				got.good_mask = result_bus.good_mask;
				got.comm_fault_mask = result_bus.comm_fault_mask;
				got.degraded = result_bus.degraded;
				got.mux_alarm = result_bus.mux_alarm;
				got.mux_reset_request = result_bus.mux_reset_request;
				got.round_count = result_bus.round_count;
				if (pending_reports.size() == 0) begin
					errors++;
					$error("result beat arrived with no item waiting for it");
				end else begin
					want = pending_reports.pop_front();
					check_field("read_status_now", 32'(want.read_status_now),
						32'(got.read_status_now));
					check_field("result_channel", 32'(want.result_channel),
						32'(got.result_channel));
					check_field("angle_value", 32'(want.angle_value), 32'(got.angle_value));
					check_field("agc_value", 32'(want.agc_value), 32'(got.agc_value));
					check_field("channel_good", 32'(want.channel_good), 32'(got.channel_good));
					check_field("recover_pending", 32'(want.recover_pending),
						32'(got.recover_pending));
					check_field("good_mask", 32'(want.good_mask), 32'(got.good_mask));
					check_field("comm_fault_mask", 32'(want.comm_fault_mask),
						32'(got.comm_fault_mask));
					check_field("degraded", 32'(want.degraded), 32'(got.degraded));
					check_field("mux_alarm", 32'(want.mux_alarm), 32'(got.mux_alarm));
					check_field("mux_reset_request", 32'(want.mux_reset_request),
						32'(got.mux_reset_request));
					check_field("round_count", want.round_count, got.round_count);
				end
			end
			if (item_bus.valid && item_bus.ready && cmd_t'(item_bus.cmd) != CMD_NONE) begin
				seen.cmd = item_bus.cmd;
				seen.channel = item_bus.channel;
				seen.angle_ok = item_bus.angle_ok;
				seen.angle = item_bus.angle;
				seen.status_ok = item_bus.status_ok;
				seen.magnet_present = item_bus.magnet_present;
				seen.agc_reading = item_bus.agc_reading;
				seen.recover_ok = item_bus.recover_ok;
				pending_reports.push_back(health_report(seen));
			end
			outstanding = pending_reports.size();
		end
	end

endmodule

[sim/multichannel_sensor_health_monitor_test.sv]
// ----------------------------------------------------------------------------
// multichannel_sensor_health_monitor_test
// Drives the health monitor with a short directed sequence and then with
// randomized scan rounds under several register settings, with random gaps
// and stalls on both channels, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module multichannel_sensor_health_monitor_test
	import mshm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 120;
	localparam int PHASE_BEATS    = 80;
	localparam int PHASES         = 10;

	logic              clk;
	logic              arst_n;
	logic              wr_en;
	logic [1:0]        wr_index;
	logic [BYTE_W-1:0] wr_data;

	int fail_count;
	int reports_due;
	int beats_sent;

	bit               burst_mode;
	bit               sink_burst;
	bit               long_hold_req;
	logic [MASK_W-1:0] cur_enable;

	mshm_item_if   item_bus ();
	mshm_result_if result_bus ();

	multichannel_sensor_health_monitor DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_bus),
		.result   (result_bus),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	multichannel_sensor_health_monitor_checker monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_bus    (item_bus),
		.result_bus  (result_bus),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.errors      (fail_count),
		.outstanding (reports_due)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic item_t make_item(cmd_t cmd, int ch, bit aok, int ang, bit sok, bit mag,
		int agc, bit rok);
		item_t it;
		it.cmd = cmd;
		it.channel = CH_W'(ch);
		it.angle_ok = aok;
		it.angle = RAW_W'(ang);
		it.status_ok = sok;
		it.magnet_present = mag;
		it.agc_reading = BYTE_W'(agc);
		it.recover_ok = rok;
		return it;
	endfunction

	function automatic item_t random_item();
		return make_item(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 7),
			1'($urandom_range(0, 1)), $urandom_range(0, 4095), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), $urandom_range(0, 255), 1'($urandom_range(0, 1)));
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		else if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_beat(item_t it);
		int gap;
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			item_bus.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_bus.cmd <= it.cmd;
		item_bus.channel <= it.channel;
		item_bus.angle_ok <= it.angle_ok;
		item_bus.angle <= it.angle;
		item_bus.status_ok <= it.status_ok;
		item_bus.magnet_present <= it.magnet_present;
		item_bus.agc_reading <= it.agc_reading;
		item_bus.recover_ok <= it.recover_ok;
		item_bus.valid <= 1'b1;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		item_bus.valid <= 1'b0;
		while (reports_due != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [BYTE_W-1:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic apply_config(logic [MASK_W-1:0] en, logic [BYTE_W-1:0] decim,
		logic [BYTE_W-1:0] rthr, logic [BYTE_W-1:0] mthr);
		drain();
		write_reg(REG_CHANNEL_ENABLE, BYTE_W'(en));
		write_reg(REG_STATUS_DECIM, decim);
		write_reg(REG_RECOVER_THR, rthr);
		write_reg(REG_MUX_RESET_THR, mthr);
		cur_enable = en;
	endtask

	task automatic send_round();
		item_t it;
		int    style;
		int    order [6];
		int    j;
		int    tmp;
		int    ch;
		style = $urandom_range(0, 9);
		for (int i = 0; i < 6; i++)
			order[i] = i;
		for (int i = 5; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		it = random_item();
		it.cmd = CMD_START;
		send_beat(it);
		for (int k = 0; k < 6; k++) begin
			ch = order[k];
			if (cur_enable[ch] || $urandom_range(0, 3) == 0) begin
				it = random_item();
				it.cmd = CMD_CHAN;
				it.channel = CH_W'(ch);
				if (style < 2) begin
					if ($urandom_range(0, 1) == 0) begin
						it.angle_ok = 1'b0;
					end else begin
						it.angle_ok = 1'b1;
						it.status_ok = 1'b0;
					end
				end else begin
					it.angle_ok = $urandom_range(0, 5) != 0;
					it.status_ok = $urandom_range(0, 5) != 0;
					it.magnet_present = $urandom_range(0, 4) != 0;
				end
				send_beat(it);
			end
		end
		if (style >= 7) begin
			repeat ($urandom_range(1, 4)) begin
				it = random_item();
				if ($urandom_range(0, 2) != 0)
					it.cmd = CMD_CHAN;
				send_beat(it);
			end
		end
		it = random_item();
		it.cmd = CMD_END;
		send_beat(it);
	endtask

	initial begin
		int  run_left;
		int  hold_left;
		logic level;
		run_left = 0;
		hold_left = 0;
		level = 1'b1;
		result_bus.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					if (sink_burst || $urandom_range(0, 3) != 0) begin
						level = 1'b1;
						run_left = $urandom_range(1, 12);
					end else begin
						level = 1'b0;
						run_left = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 40) :
							$urandom_range(1, 3);
					end
				end
				run_left--;
				result_bus.ready <= level;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		int start_count;
		item_t it;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		item_bus.valid <= 1'b0;
		item_bus.cmd <= '0;
		item_bus.channel <= '0;
		item_bus.angle_ok <= 1'b0;
		item_bus.angle <= '0;
		item_bus.status_ok <= 1'b0;
		item_bus.magnet_present <= 1'b0;
		item_bus.agc_reading <= '0;
		item_bus.recover_ok <= 1'b0;
		burst_mode = 1'b0;
		sink_burst = 1'b0;
		long_hold_req = 1'b0;
		cur_enable = '0;
		beats_sent = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// With the reset settings every channel is disabled.
		send_beat(make_item(CMD_START, 0, 1, 0, 1, 1, 0, 0));
		send_beat(make_item(CMD_CHAN, 0, 1, 12'h123, 1, 1, 8'h40, 0));
		send_beat(make_item(CMD_END, 0, 0, 0, 0, 0, 0, 1));

		// All channels on, status read every round, lowest thresholds.
		apply_config(6'h3F, 8'd0, 8'd1, 8'd1);
		send_beat(make_item(CMD_NONE, 7, 1, 4095, 1, 1, 255, 1));
		send_beat(make_item(CMD_START, 0, 0, 0, 0, 0, 0, 0));
		send_beat(make_item(CMD_CHAN, 0, 1, 4095, 1, 1, 255, 0));
		send_beat(make_item(CMD_CHAN, 1, 1, 0, 0, 1, 0, 0));
		send_beat(make_item(CMD_CHAN, 2, 0, 1234, 1, 1, 77, 0));
		send_beat(make_item(CMD_CHAN, 3, 1, 2048, 1, 0, 0, 0));
		send_beat(make_item(CMD_CHAN, 6, 1, 100, 1, 1, 10, 1));
		send_beat(make_item(CMD_CHAN, 7, 0, 4095, 0, 0, 255, 1));
		send_beat(make_item(CMD_END, 0, 0, 0, 0, 0, 0, 0));

		// Every enabled channel fails, so the mux reset fires at once.
		send_beat(make_item(CMD_START, 0, 0, 0, 0, 0, 0, 0));
		for (int c = 0; c < 6; c++)
			send_beat(make_item(CMD_CHAN, c, 0, 4095 - c, 1, 1, 200, 0));
		send_beat(make_item(CMD_END, 0, 0, 0, 0, 0, 0, 1));

		// An item for a disabled channel leaves its stores alone.
		apply_config(6'b000101, 8'd0, 8'd1, 8'd1);
		send_beat(make_item(CMD_START, 0, 0, 0, 0, 0, 0, 0));
		send_beat(make_item(CMD_CHAN, 1, 1, 555, 1, 1, 33, 0));
		send_beat(make_item(CMD_CHAN, 0, 1, 777, 1, 1, 99, 0));
		send_beat(make_item(CMD_END, 0, 0, 0, 0, 0, 0, 1));

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: apply_config(6'h3F, 8'd1, 8'd3, 8'd3);
				1: apply_config(MASK_W'($urandom_range(0, 63)) | 6'h01, 8'd255, 8'd255, 8'd255);
				2: apply_config(6'h00, 8'd0, 8'd1, 8'd1);
				3: apply_config(6'h3F, 8'd3, 8'd2, 8'd1);
				default: apply_config(MASK_W'($urandom_range(0, 63)), BYTE_W'($urandom_range(0, 6)),
					BYTE_W'($urandom_range(1, 5)), BYTE_W'($urandom_range(1, 4)));
			endcase
			burst_mode = (p % 3) == 1;
			sink_burst = (p % 4) == 3;
			if (p == 4 || p == 7)
				long_hold_req = 1'b1;
			if (p == 1) begin
				// One long round drives the failure streak of channel 0 into saturation.
				send_beat(make_item(CMD_START, 0, 0, 0, 0, 0, 0, 0));
				repeat (300) begin
					it = random_item();
					it.cmd = CMD_CHAN;
					it.channel = '0;
					it.angle_ok = 1'b0;
					send_beat(it);
				end
				send_beat(make_item(CMD_END, 0, 0, 0, 0, 0, 0, 0));
			end
			start_count = beats_sent;
			while (beats_sent - start_count < PHASE_BEATS) begin
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 5)) send_beat(random_item());
				end else begin
					send_round();
				end
			end
		end

		drain();
		if (fail_count == 0 && reports_due == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
